@@ rtl/knob_and_button_event_classifier_unit_assert.svh @@
// assertion macros for the knob and button event classifier checker
// no dependencies; included by the checker file
`ifndef KNOB_AND_BUTTON_EVENT_CLASSIFIER_UNIT_ASSERT_SVH
`define KNOB_AND_BUTTON_EVENT_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KBEC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define KBEC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/kbec_pkg.sv @@
// shared types and constants for the knob and button event classifier
// no dependencies
package kbec_pkg;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_CW     = 3'd4,
    EV_CCW    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_DOUBLE_CLICK = 2'd1,
    CFG_DETENT       = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] LONG_PRESS_RST   = 16'd600;
  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;
  localparam logic [2:0]  DETENT_RST       = 3'd2;

  typedef struct packed {
    logic [15:0] long_ms;
    logic [15:0] dbl_ms;
    logic [2:0]  detent;
  } cfg_t;

  typedef struct packed {
    logic hit;
    logic cw;
  } rot_t;

endpackage

@@ rtl/kbec_rotary.sv @@
// quadrature decoder: level history, signed step count and detent compare
// depends on kbec_pkg
module kbec_rotary
  import kbec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       enc_a_i,
  input  logic       enc_b_i,
  input  logic [2:0] detent_i,
  output rot_t       rot_o
);

  logic [3:0]        hist_q, hist_d;
  logic signed [3:0] cnt_q, cnt_d, cnt_n, det_s;

  always_comb begin
    hist_d = {hist_q[1:0], enc_a_i, enc_b_i};
    case (hist_d)
      // clockwise transitions
      4'b1101, 4'b0100, 4'b0010, 4'b1011: cnt_n = cnt_q + 4'sd1;
      // counter-clockwise transitions
      4'b1110, 4'b0111, 4'b0001, 4'b1000: cnt_n = cnt_q - 4'sd1;
      default: cnt_n = cnt_q;
    endcase
    // a zero detent behaves as one
    det_s = (detent_i == 3'd0) ? 4'sd1 : $signed({1'b0, detent_i});
    rot_o.cw  = (cnt_n >= det_s);
    rot_o.hit = rot_o.cw || (cnt_n <= -det_s);
    cnt_d = rot_o.hit ? 4'sd0 : cnt_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= 4'd0;
      cnt_q  <= 4'sd0;
    end else if (adv_i) begin
      hist_q <= hist_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ rtl/kbec_button.sv @@
// push switch timing: long press, double click and delayed single click
// depends on kbec_pkg
module kbec_button
  import kbec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        skip_i,
  input  logic        pressed_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  output event_e      ev_o
);

  logic        held_q, held_d;
  logic        pend_q, pend_d;
  logic [31:0] start_q, start_d;
  logic [31:0] click_q, click_d;
  logic [31:0] dur, gap;

  always_comb begin
    held_d  = held_q;
    pend_d  = pend_q;
    start_d = start_q;
    click_d = click_q;
    ev_o    = EV_NONE;
    // differences wrap modulo 2^32
    dur = now_i - start_q;
    gap = now_i - click_q;
    if (!skip_i) begin
      if (pressed_i && !held_q) begin
        held_d  = 1'b1;
        start_d = now_i;
      end
      if (!pressed_i && held_q) begin
        held_d = 1'b0;
        if (dur > {16'd0, cfg_i.long_ms}) begin
          ev_o = EV_LONG;
        end else if (pend_q && (gap < {16'd0, cfg_i.dbl_ms})) begin
          pend_d = 1'b0;
          ev_o   = EV_DOUBLE;
        end else begin
          // a fresh pending click cannot expire on the same sample
          pend_d  = 1'b1;
          click_d = now_i;
        end
      end else if (pend_q && (gap > {16'd0, cfg_i.dbl_ms})) begin
        pend_d = 1'b0;
        ev_o   = EV_CLICK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      pend_q  <= 1'b0;
      start_q <= 32'd0;
      click_q <= 32'd0;
    end else if (adv_i) begin
      held_q  <= held_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      click_q <= click_d;
    end
  end

endmodule

@@ rtl/knob_and_button_event_classifier_unit.sv @@
// Knob and button event classifier. One sample (encoder levels, switch level,
// millisecond time) is taken per cycle and gives exactly one event word. An
// accepted sample waits in the sample register, then its decode is written into
// the event register, which drives out_valid_o. The sustained rate is one sample
// per clock, as the encoder and switch state update with each sample that moves
// on; it drops only while the event register is stalled by out_ready_i. Registers
// are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only
// while no sample is in flight, as the block does not enforce this; index 3 is ignored.
module knob_and_button_event_classifier_unit
  import kbec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        enc_a_i,
  input  logic        enc_b_i,
  input  logic        switch_pressed_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o
);

  cfg_t        cfg_q;
  logic        smp_v_q;
  logic        a_q, b_q, p_q;
  logic [31:0] t_q;
  logic        out_v_q;
  event_e      ev_q, ev_d, btn_ev;
  rot_t        rot;
  logic        adv;

  // sample register moves on when the event register is free or draining
  assign adv        = smp_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !smp_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ms <= LONG_PRESS_RST;
      cfg_q.dbl_ms  <= DOUBLE_CLICK_RST;
      cfg_q.detent  <= DETENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LONG_PRESS:   cfg_q.long_ms <= cfg_data_i;
        CFG_DOUBLE_CLICK: cfg_q.dbl_ms  <= cfg_data_i;
        CFG_DETENT:       cfg_q.detent  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        smp_v_q <= in_valid_i;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= enc_a_i;
      b_q <= enc_b_i;
      p_q <= switch_pressed_i;
      t_q <= time_ms_i;
    end
    if (adv) begin
      ev_q <= ev_d;
    end
  end

  kbec_rotary u_rotary (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .enc_a_i  (a_q),
    .enc_b_i  (b_q),
    .detent_i (cfg_q.detent),
    .rot_o    (rot)
  );

  // a rotation on this sample masks the switch
  kbec_button u_button (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .skip_i    (rot.hit),
    .pressed_i (p_q),
    .now_i     (t_q),
    .cfg_i     (cfg_q),
    .ev_o      (btn_ev)
  );

  assign ev_d        = rot.hit ? (rot.cw ? EV_CW : EV_CCW) : btn_ev;
  assign out_valid_o = out_v_q;
  assign event_res_o = ev_q;

endmodule

@@ rtl/kbec_checker.sv @@
// port-level checker for the knob and button event classifier, bound to the top
// depends on knob_and_button_event_classifier_unit_assert.svh
`include "knob_and_button_event_classifier_unit_assert.svh"

module kbec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        enc_a_i,
  input logic        enc_b_i,
  input logic        switch_pressed_i,
  input logic [31:0] time_ms_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_res_o
);

  logic [1:0] flight_q;
  logic       in_acc, out_acc;
  logic       unused_ok;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  // payload and config ports are seen but not checked here
  assign unused_ok = ^{cfg_we_i, cfg_idx_i, cfg_data_i, enc_a_i, enc_b_i,
                       switch_pressed_i, time_ms_i};

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      flight_q <= flight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      flight_q <= flight_q - 2'd1;
    end
  end

  `KBEC_ASSERT_NOW(a_ev_range, clk_i, rst_ni, out_valid_o, event_res_o <= 3'd5 || unused_ok, "event code out of range")
  `KBEC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(event_res_o), "stalled event changed")
  `KBEC_ASSERT_NOW(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o, "not ready with empty output")
  `KBEC_ASSERT_NOW(a_flight, clk_i, rst_ni, out_valid_o, flight_q != 2'd0 && flight_q != 2'd3, "event without sample or too many in flight")

endmodule

bind knob_and_button_event_classifier_unit kbec_checker u_kbec_checker (.*);

@@ tb/tb_knob_and_button_event_classifier_unit.sv @@
// self-checking testbench for the knob and button event classifier
// depends on kbec_pkg and knob_and_button_event_classifier_unit; drives samples with
// random bursts and stalls, predicts each event word and checks it in order
module tb_knob_and_button_event_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kbec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef struct packed {
    logic        a;
    logic        b;
    logic        pressed;
    logic [31:0] t;
  } knob_sample_t;

  typedef enum logic [1:0] {ENC_STILL, ENC_CW, ENC_CCW, ENC_WANDER} enc_motion_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        enc_a_i;
  logic        enc_b_i;
  logic        switch_pressed_i;
  logic [31:0] time_ms_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  event_res_o;

  knob_sample_t drv_word;
  assign enc_a_i          = drv_word.a;
  assign enc_b_i          = drv_word.b;
  assign switch_pressed_i = drv_word.pressed;
  assign time_ms_i        = drv_word.t;

  knob_and_button_event_classifier_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .enc_a_i          (enc_a_i),
    .enc_b_i          (enc_b_i),
    .switch_pressed_i (switch_pressed_i),
    .time_ms_i        (time_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o)
  );

  knob_sample_t pending_samples[$];
  event_e       expected_events[$];

  // shadow of the block's registers and state
  logic [15:0]       long_ms_cfg;
  logic [15:0]       dbl_ms_cfg;
  logic [2:0]        detent_cfg;
  logic [3:0]        enc_hist;
  logic signed [3:0] step_acc;
  logic              sw_held;
  logic [31:0]       press_t;
  logic              click_wait;
  logic [31:0]       click_t;

  // stimulus generator state
  logic [1:0]   enc_pos;
  enc_motion_e  enc_motion;
  logic [31:0]  last_rel;
  int unsigned  items_made;
  int unsigned  phase_n;

  bit           word_taken;
  int unsigned  burst_left;
  int unsigned  gap_left;
  rx_pattern_e  rx_pattern;
  int unsigned  rx_left;
  event_e       want_event;
  int unsigned  err_count;
  int unsigned  cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic event_e classify_sample(knob_sample_t s);
    logic signed [3:0] det;
    logic [31:0]       dur;
    logic [31:0]       since_click;
    det = (detent_cfg == 3'd0) ? 4'sd1 : $signed({1'b0, detent_cfg});
    enc_hist = {enc_hist[1:0], s.a, s.b};
    // gray-code history: previous pair in the upper bits
    case (enc_hist)
      4'b1101, 4'b0100, 4'b0010, 4'b1011: step_acc = step_acc + 4'sd1;
      4'b1110, 4'b0111, 4'b0001, 4'b1000: step_acc = step_acc - 4'sd1;
      default: ;
    endcase
    if (step_acc >= det) begin
      step_acc = '0;
      return EV_CW;
    end
    if (step_acc <= -det) begin
      step_acc = '0;
      return EV_CCW;
    end
    if (s.pressed && !sw_held) begin
      sw_held = 1'b1;
      press_t = s.t;
    end
    if (!s.pressed && sw_held) begin
      dur = s.t - press_t;
      since_click = s.t - click_t;
      sw_held = 1'b0;
      if (dur > {16'd0, long_ms_cfg}) return EV_LONG;
      if (click_wait && since_click < {16'd0, dbl_ms_cfg}) begin
        click_wait = 1'b0;
        return EV_DOUBLE;
      end
      click_wait = 1'b1;
      click_t = s.t;
    end
    since_click = s.t - click_t;
    if (click_wait && since_click > {16'd0, dbl_ms_cfg}) begin
      click_wait = 1'b0;
      return EV_CLICK;
    end
    return EV_NONE;
  endfunction

  task automatic report_mismatch(string what, logic [2:0] got, logic [2:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LONG_PRESS:   long_ms_cfg = value;
      CFG_DOUBLE_CLICK: dbl_ms_cfg  = value;
      CFG_DETENT:       detent_cfg  = value[2:0];
      default: ;
    endcase
  endtask

  task automatic queue_sample(logic a, logic b, logic pressed, logic [31:0] t);
    knob_sample_t s;
    s.a = a;
    s.b = b;
    s.pressed = pressed;
    s.t = t;
    pending_samples.push_back(s);
    items_made++;
  endtask

  // moves the encoder as the current gesture's motion says, then queues the sample
  task automatic queue_level(logic pressed, logic [31:0] t);
    case (enc_motion)
      ENC_CW:     if ($urandom_range(0, 3) != 0) enc_pos = enc_pos + 2'd1;
      ENC_CCW:    if ($urandom_range(0, 3) != 0) enc_pos = enc_pos - 2'd1;
      ENC_WANDER: enc_pos = enc_pos + 2'($urandom_range(0, 3));
      default: ;
    endcase
    case (enc_pos)
      2'd0: queue_sample(1'b0, 1'b0, pressed, t);
      2'd1: queue_sample(1'b1, 1'b0, pressed, t);
      2'd2: queue_sample(1'b1, 1'b1, pressed, t);
      default: queue_sample(1'b0, 1'b1, pressed, t);
    endcase
  endtask

  // one press and release, timed around the current thresholds
  task automatic queue_gesture();
    logic [31:0] lp, dp, hold_ms, rr_ms, press_at, span;
    int unsigned n_idle, n_hold, k;
    lp = {16'd0, long_ms_cfg};
    dp = {16'd0, dbl_ms_cfg};
    enc_motion = enc_motion_e'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: hold_ms = lp - 1;
      1: hold_ms = lp;
      2: hold_ms = lp + 1;
      3: hold_ms = lp + $urandom_range(2, 2 * lp + 2);
      default: hold_ms = $urandom_range(0, lp / 2);
    endcase
    // spacing from the previous release to this one
    case ($urandom_range(0, 5))
      0: rr_ms = dp - 1;
      1: rr_ms = dp;
      2: rr_ms = dp + 1;
      3: rr_ms = dp + $urandom_range(2, 2 * dp + 2);
      default: rr_ms = $urandom_range(0, dp);
    endcase
    if (rr_ms > hold_ms) press_at = last_rel + rr_ms - hold_ms;
    else press_at = last_rel + $urandom_range(0, 3);
    span = press_at - last_rel;
    if ($urandom_range(0, 3) == 0 && span > dp + 1) begin
      queue_level(1'b0, last_rel + dp);
      queue_level(1'b0, last_rel + dp + 1);
    end else begin
      n_idle = $urandom_range(0, 3);
      for (k = 1; k <= n_idle; k++) queue_level(1'b0, last_rel + span * k / (n_idle + 1));
    end
    queue_level(1'b1, press_at);
    n_hold = $urandom_range(0, 3);
    for (k = 1; k <= n_hold; k++) queue_level(1'b1, press_at + hold_ms * k / (n_hold + 1));
    last_rel = press_at + hold_ms;
    queue_level(1'b0, last_rel);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned target;
    target = items_made + count;
    last_rel = $urandom;
    while (items_made < target) begin
      if ($urandom_range(0, 9) == 0)
        queue_sample(1'($urandom), 1'($urandom), 1'($urandom), $urandom);
      else
        queue_gesture();
    end
  endtask

  task automatic queue_directed();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    queue_sample(1'b0, 1'b0, 1'b0, t0);
    queue_sample(1'b1, 1'b0, 1'b0, t0 + 1);
    // rotation with the switch going down on the same word
    queue_sample(1'b1, 1'b1, 1'b1, t0 + 2);
    queue_sample(1'b1, 1'b1, 1'b1, t0 + 10);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 110);
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 200);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 255);
    // timestamp wraps to zero here
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 256);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 1000);
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 1100);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 1200);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 1500);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 1501);
    // press exactly as long as the threshold, then a long press over a waiting click
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 1600);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 2200);
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 2300);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 2950);
    // illegal encoder jumps
    queue_sample(1'b1, 1'b0, 1'b0, t0 + 2951);
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 3000);
    queue_sample(1'b0, 1'b1, 1'b0, t0 + 3100);
    queue_sample(1'b0, 1'b1, 1'b1, t0 + 3200);
    // second release right on the window edge
    queue_sample(1'b1, 1'b1, 1'b0, t0 + 3400);
    queue_sample(1'b1, 1'b0, 1'b1, t0 + 3450);
    // ccw rotation hides the release until the next word
    queue_sample(1'b0, 1'b0, 1'b0, t0 + 3500);
    queue_sample(1'b0, 1'b0, 1'b0, t0 + 3520);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid_i || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sender: bursts of words with random gaps in between
  always @(negedge clk_i) begin
    if (word_taken) word_taken <= 1'b0;
    if (rst_ni && !(in_valid_i && !word_taken)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending_samples.size() != 0) begin
        drv_word   <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_events.push_back(classify_sample(drv_word));
      word_taken <= 1'b1;
    end
  end

  // receiver stalls follow a pattern that is chosen anew at random when its run ends
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 60);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom);
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (rx_left % 7) != 0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event word with nothing expected", event_res_o, EV_NONE);
      end else begin
        want_event = expected_events.pop_front();
        if (event_res_o !== want_event)
          report_mismatch("event_res", event_res_o, want_event);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_LONG_PRESS;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    drv_word    = '0;
    word_taken  = 1'b0;
    burst_left  = 0;
    gap_left    = 0;
    rx_pattern  = RX_OPEN;
    rx_left     = 0;
    err_count   = 0;
    cycle_count = 0;
    items_made  = 0;
    enc_pos     = 2'd0;
    enc_motion  = ENC_STILL;
    last_rel    = '0;
    long_ms_cfg = LONG_PRESS_RST;
    dbl_ms_cfg  = DOUBLE_CLICK_RST;
    detent_cfg  = DETENT_RST;
    enc_hist    = '0;
    step_acc    = '0;
    sw_held     = 1'b0;
    press_t     = '0;
    click_wait  = 1'b0;
    click_t     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_directed();
    wait_drained();

    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    write_reg(CFG_DOUBLE_CLICK, 16'hFFFF);
    write_reg(CFG_DETENT, 16'd7);
    queue_random(200);
    wait_drained();

    write_reg(CFG_LONG_PRESS, 16'd1);
    write_reg(CFG_DOUBLE_CLICK, 16'd1);
    write_reg(CFG_DETENT, 16'd1);
    queue_random(200);
    wait_drained();

    // zero detent behaves as one; sender held off mid-run until all events are back
    write_reg(CFG_LONG_PRESS, LONG_PRESS_RST);
    write_reg(CFG_DOUBLE_CLICK, DOUBLE_CLICK_RST);
    write_reg(CFG_DETENT, 16'd0);
    queue_random(100);
    wait_drained();
    queue_random(100);
    wait_drained();

    for (phase_n = 0; phase_n < 4; phase_n++) begin
      write_reg(CFG_LONG_PRESS, 16'($urandom_range(1, 3000)));
      write_reg(CFG_DOUBLE_CLICK, 16'($urandom_range(1, 1500)));
      write_reg(CFG_DETENT, {13'($urandom), 3'($urandom_range(0, 7))});
      queue_random(200);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kbec_pkg.sv
rtl/kbec_rotary.sv
rtl/kbec_button.sv
rtl/knob_and_button_event_classifier_unit.sv
rtl/kbec_checker.sv
tb/tb_knob_and_button_event_classifier_unit.sv
